@@ hw/rtl/bmh_pkg.sv @@
// bmh_pkg: types, constants and mixing functions for the byte mixing hash.
// No dependencies; used by the interfaces, the core and its checker.
`default_nettype none

package bmh_pkg;

   localparam int WordBits  = 32;
   localparam int NumWords  = 4;
   localparam int ByteBits  = 8;
   localparam int GroupBits = 64;

   typedef logic [WordBits-1:0]  word_type;
   typedef logic [ByteBits-1:0]  byte_type;
   typedef logic [GroupBits-1:0] group_type;
   typedef word_type [NumWords-1:0] mix_type;

   localparam mix_type InitWords = {32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};
   localparam mix_type MulWords  = {32'h010001e7, 32'h010001c3, 32'h010001b7, 32'h01000193};

   // One byte absorbed into the four words. Word 3 sees the new word 0.
   function automatic mix_type absorb(mix_type w, byte_type b);
      word_type m;
      mix_type  n;
      m = {24'd0, b ^ w[0][7:0]};
      n[0] = (w[0] ^ word_type'(m * MulWords[0])) + (w[1] >> 3);
      n[1] = (w[1] ^ word_type'(m * MulWords[1])) + (w[2] >> 5);
      n[2] = (w[2] ^ word_type'(m * MulWords[2])) + (w[3] >> 7);
      n[3] = (w[3] ^ word_type'(m * MulWords[3])) + (n[0] >> 11);
      return n;
   endfunction

   // Digest byte i is the word shifted right by 4i; bytes overlap by a nibble.
   function automatic group_type spread(word_type w);
      group_type g;
      word_type  s;
      g = '0;
      for (int i = 0; i < 8; i++) begin
         s = w >> (4 * i);
         g[8*i +: 8] = s[7:0];
      end
      return g;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bmh_if.sv @@
// bmh_req_if / bmh_rsp_if: valid/ready channels for message items and digests.
// Depends on bmh_pkg.
`default_nettype none

interface bmh_req_if;
   import bmh_pkg::*;
   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     has_byte;
   logic     last;

   modport source (output valid, data_byte, has_byte, last, input ready);
   modport sink   (input valid, data_byte, has_byte, last, output ready);
endinterface

interface bmh_rsp_if;
   import bmh_pkg::*;
   logic      valid;
   logic      ready;
   group_type digest_group0;
   group_type digest_group1;
   group_type digest_group2;
   group_type digest_group3;

   modport source (output valid, digest_group0, digest_group1, digest_group2,
                   digest_group3, input ready);
   modport sink   (input valid, digest_group0, digest_group1, digest_group2,
                   digest_group3, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/byte_mixing_hash_core.sv @@
// byte_mixing_hash_core: four-word byte mixing hash with a 32-byte digest.
// Depends on bmh_pkg and the channel interfaces in bmh_if.sv.
//
// Usage:
//   req_ch carries one item per handshake: data_byte, has_byte and last.
//   An item with has_byte set absorbs its byte; an item with last set ends
//   the message and produces one digest item on rsp_ch (the byte, if any,
//   is absorbed first). An item with only last set is an empty message.
//   Items without last produce nothing on rsp_ch.
// Timing:
//   Accepted items land in an input register; from there the mixing logic
//   updates the four state words. A digest goes through the input register
//   and then the digest register to rsp_ch. One item per cycle is sustained
//   while no last item waits behind a held digest; words_ff closes the loop.
// Reset:
//   Synchronous, active high. Clears both stages and loads the initial words.
// Stalls:
//   The digest register holds until rsp_ch.ready. Meanwhile non-last items
//   keep flowing; a second last item waits in the input register and
//   req_ch.ready drops only then.
`default_nettype none

module byte_mixing_hash_core (
   input  wire      clock,
   input  wire      reset,
   bmh_req_if.sink  req_ch,
   bmh_rsp_if.source rsp_ch
);
   import bmh_pkg::*;

   logic     s1_valid_ff;
   byte_type s1_byte_ff;
   logic     s1_has_ff;
   logic     s1_last_ff;
   logic     s1_advance;

   mix_type  words_ff, words_in;
   mix_type  absorbed;
   logic     out_valid_ff, out_valid_in;
   mix_type  out_words_ff;
   logic     req_take;

   always_comb begin
      s1_advance = s1_valid_ff && (!s1_last_ff || !out_valid_ff || rsp_ch.ready);
      absorbed   = s1_has_ff ? absorb(words_ff, s1_byte_ff) : words_ff;
      req_take   = req_ch.valid && req_ch.ready;

      words_in = words_ff;
      if (s1_advance) begin
         words_in = s1_last_ff ? InitWords : absorbed;
      end

      out_valid_in = out_valid_ff && !rsp_ch.ready;
      if (s1_advance && s1_last_ff) begin
         out_valid_in = 1'b1;
      end
   end

   assign req_ch.ready = !s1_valid_ff || s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         words_ff     <= InitWords;
      end else begin
         if (req_ch.ready) begin
            s1_valid_ff <= req_ch.valid;
         end
         out_valid_ff <= out_valid_in;
         words_ff     <= words_in;
      end
      if (req_take) begin
         s1_byte_ff <= req_ch.data_byte;
         s1_has_ff  <= req_ch.has_byte;
         s1_last_ff <= req_ch.last;
      end
      if (s1_advance && s1_last_ff) begin
         out_words_ff <= absorbed;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.digest_group0 = spread(out_words_ff[0]);
   assign rsp_ch.digest_group1 = spread(out_words_ff[1]);
   assign rsp_ch.digest_group2 = spread(out_words_ff[2]);
   assign rsp_ch.digest_group3 = spread(out_words_ff[3]);

endmodule

`default_nettype wire

@@ hw/rtl/bmh_checker.sv @@
// bmh_checker: port-level assertions for byte_mixing_hash_core, bound to it.
// Depends on bmh_pkg and byte_mixing_hash_core.
`default_nettype none

module bmh_checker (
   input wire                     clock,
   input wire                     reset,
   input wire                     req_valid,
   input wire                     req_ready,
   input wire                     req_last,
   input wire                     rsp_valid,
   input wire                     rsp_ready,
   input wire bmh_pkg::group_type rsp_group0,
   input wire bmh_pkg::group_type rsp_group3
);
   import bmh_pkg::*;

   // A stalled digest item stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_group0) && $stable(rsp_group3))
      else $error("digest changed while stalled");

   // The input only backs up behind a waiting digest.
   a_req_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // A fresh digest follows a last item through the input and digest registers.
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last, 2))
      else $error("digest without matching last item");

endmodule

bind byte_mixing_hash_core bmh_checker u_bmh_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .req_last   (req_ch.last),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_group0 (rsp_ch.digest_group0),
   .rsp_group3 (rsp_ch.digest_group3)
);

`default_nettype wire
